// ===== src/ipf_pkg.sv =====
// Shared types and constants for the IMU packet framer with check-word test.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipf_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SECOND = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] HEAD_BYTE_RST  = 8'h3A;
    localparam logic [7:0] END_FIRST_RST  = 8'h0D;
    localparam logic [7:0] END_SECOND_RST = 8'h0A;

    // Frame status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Positions within a frame
    localparam logic [7:0] POS_CMD_LO    = 8'd3;
    localparam logic [7:0] POS_CMD_HI    = 8'd4;
    localparam logic [7:0] POS_SUM_START = 8'd5;
    localparam logic [7:0] POS_ANG_FIRST = 8'd19;
    localparam logic [7:0] POS_ANG_LAST  = 8'd22;
    localparam logic [7:0] LEN_MIN_CHECK = 8'd5;
    localparam logic [7:0] LEN_MIN_ANGLE = 8'd23;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Width of the packed result on the output stream
    localparam int M_TDATA_W = 64;

    // One closed or aborted frame, as handed from front to back
    typedef struct packed {
        logic        overflow;   // length bound hit
        logic        len_ge5;    // long enough to hold a check word
        logic        len_ge23;   // long enough to hold the angle bytes
        logic [15:0] sum;        // running sum up to the byte before the check word
        logic [15:0] check_word; // little-endian check word from the frame
        logic [15:0] command;
        logic [6:0]  length;
        logic [31:0] angle;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

// ===== src/imu_packet_framer_lrc_check_top.sv =====
// Top level of the IMU packet framer with 16-bit additive check word.
// Depends on ipf_pkg, ipf_front, ipf_queue and ipf_back.
//
//  Channel   Direction  Width  Content
//  s_        in         8      one received byte (rx_byte)
//  m_        out        64     one frame report per closed or aborted frame
//  cfg_      in         8      head_byte / end_first / end_second writes
//
// One byte is taken per cycle while s_tready is high; the frame state, the running sum
// and the end pair detection all resolve in that cycle in the front part.
// A report reaches m_tvalid through the queue, then the output register.
// The four-entry report queue decouples the two sides:
// s_tready drops only while the queue is full under a stalled m_tready.
// aresetn is synchronous, active low; no clearing pass is needed.
`default_nettype none

module imu_packet_framer_lrc_check_top #(
    // Frame length bound in bytes, 8 to 127
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Configuration write port
    input  wire                          cfg_wr_en,
    input  wire [ipf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [7:0]                    cfg_wdata,
    // Byte stream in
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [7:0]                    s_tdata,   // [7:0] rx_byte
    // Report stream out
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [1:0] frame_status, [17:2] command_word, [24:18] frame_length,
    // [56:25] angle_bits, [63:57] zero
    output logic [ipf_pkg::M_TDATA_W-1:0] m_tdata
);
    import ipf_pkg::*;

    logic        rec_push, rec_pop;
    frame_rec_t  front_rec, queue_rec;
    queue_stat_t q_stat;

    // Bytes are only refused while a report could not be stored
    assign s_tready = !q_stat.full;

    ipf_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (s_tvalid && s_tready),
        .rx_byte    (s_tdata),
        .rec_push   (rec_push),
        .rec_data   (front_rec)
    );

    ipf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (front_rec),
        .pop       (rec_pop),
        .pop_data  (queue_rec),
        .stat      (q_stat)
    );

    ipf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_avail (!q_stat.empty),
        .rec_data  (queue_rec),
        .rec_pop   (rec_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/ipf_front.sv =====
// Front part: configuration registers, frame hunting, byte storage, running sum.
// Depends on ipf_pkg; pushes one frame_rec_t per closed or aborted frame.
`default_nettype none

module ipf_front #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [ipf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [7:0]                    cfg_wdata,
    input  wire                          byte_valid,
    input  wire [7:0]                    rx_byte,
    output logic                         rec_push,
    output ipf_pkg::frame_rec_t          rec_data
);
    import ipf_pkg::*;

    localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [7:0] MAX_BYTES = 8'(MAX_FRAME_BYTES);

    logic [7:0]         head_reg, endf_reg, ends_reg;
    logic               in_frame_reg, in_frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         recent_reg  [4];
    logic [7:0]         recent_next [4];
    logic [15:0]        cmd_reg, cmd_next;
    logic [31:0]        angle_reg, angle_next;

    logic               take;
    logic [COUNT_W-1:0] cur_count;
    logic [15:0]        cur_sum, cur_cmd;
    logic [31:0]        cur_angle;
    logic [7:0]         cur_recent [4];
    logic [7:0]         pos8, len8;
    logic [1:0]         ang_idx;
    logic               closing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= HEAD_BYTE_RST;
            endf_reg <= END_FIRST_RST;
            ends_reg <= END_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEAD_BYTE:  head_reg <= cfg_wdata;
                CFG_END_FIRST:  endf_reg <= cfg_wdata;
                CFG_END_SECOND: ends_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        // A head byte while hunting starts a fresh, cleared frame
        take = byte_valid && (in_frame_reg || (rx_byte == head_reg));
        cur_count = in_frame_reg ? count_reg : '0;
        cur_sum   = in_frame_reg ? sum_reg   : '0;
        cur_cmd   = in_frame_reg ? cmd_reg   : '0;
        cur_angle = in_frame_reg ? angle_reg : '0;
        for (int i = 0; i < 4; i++) begin
            cur_recent[i] = in_frame_reg ? recent_reg[i] : 8'd0;
        end
        pos8    = 8'(cur_count);
        ang_idx = 2'(pos8 - POS_ANG_FIRST);

        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        cmd_next      = cmd_reg;
        angle_next    = angle_reg;
        for (int i = 0; i < 4; i++) begin
            recent_next[i] = recent_reg[i];
        end
        closing  = 1'b0;
        rec_push = 1'b0;
        len8     = pos8;

        rec_data.overflow   = 1'b0;
        rec_data.sum        = cur_sum;
        rec_data.check_word = {cur_recent[1], cur_recent[2]};
        rec_data.command    = cur_cmd;
        rec_data.angle      = cur_angle;

        if (take) begin
            if (pos8 >= MAX_BYTES) begin
                // Byte dropped, frame aborted
                rec_push          = 1'b1;
                rec_data.overflow = 1'b1;
                in_frame_next     = 1'b0;
            end else begin
                sum_next = cur_sum;
                if (pos8 >= POS_SUM_START) begin
                    sum_next = cur_sum + 16'(cur_recent[3]);
                end
                recent_next[3] = cur_recent[2];
                recent_next[2] = cur_recent[1];
                recent_next[1] = cur_recent[0];
                recent_next[0] = rx_byte;

                cmd_next = cur_cmd;
                if (pos8 == POS_CMD_LO) cmd_next[7:0]  = rx_byte;
                if (pos8 == POS_CMD_HI) cmd_next[15:8] = rx_byte;
                angle_next = cur_angle;
                if (pos8 >= POS_ANG_FIRST && pos8 <= POS_ANG_LAST) begin
                    angle_next[ang_idx*8 +: 8] = rx_byte;
                end

                count_next = cur_count + 1'b1;
                len8       = pos8 + 8'd1;
                closing    = (len8 >= 8'd2) && (cur_recent[0] == endf_reg)
                             && (rx_byte == ends_reg);

                rec_push         = closing;
                rec_data.sum     = sum_next;
                rec_data.command = cmd_next;
                rec_data.angle   = angle_next;
                in_frame_next    = !closing;
            end
        end

        rec_data.length   = 7'(len8);
        rec_data.len_ge5  = len8 >= LEN_MIN_CHECK;
        rec_data.len_ge23 = len8 >= LEN_MIN_ANGLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        cmd_reg   <= cmd_next;
        angle_reg <= angle_next;
        for (int i = 0; i < 4; i++) begin
            recent_reg[i] <= recent_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== src/ipf_queue.sv =====
// Short register queue of frame records between front and back.
// Depends on ipf_pkg for frame_rec_t and the queue depth.
`default_nettype none

module ipf_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  ipf_pkg::frame_rec_t  push_data,
    input  wire                  pop,
    output ipf_pkg::frame_rec_t  pop_data,
    output ipf_pkg::queue_stat_t stat
);
    import ipf_pkg::*;

    frame_rec_t        store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = store_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) fill_next = fill_reg + 1'b1;
        if (do_pop && !do_push) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== src/ipf_back.sv =====
// Back part: check-word comparison, status coding and the output register.
// Depends on ipf_pkg; pulls frame records from ipf_queue.
`default_nettype none

module ipf_back (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             rec_avail,
    input  ipf_pkg::frame_rec_t             rec_data,
    output logic                            rec_pop,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [ipf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ipf_pkg::*;

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg, data_next;
    logic [1:0]           status;
    logic [31:0]          angle;

    assign rec_pop  = rec_avail && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        if (rec_data.overflow) begin
            status = STAT_OVERFLOW;
        end else if (rec_data.len_ge5 && (rec_data.check_word == rec_data.sum)) begin
            status = STAT_OK;
        end else begin
            status = STAT_MISMATCH;
        end
        angle     = rec_data.len_ge23 ? rec_data.angle : 32'd0;
        data_next = {7'd0, angle, rec_data.length, rec_data.command, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for imu_packet_framer_lrc_check_top: byte frames in, frame reports out.
// Depends on ipf_pkg and the block's RTL; the expected reports come from a predictor built in.

module testbench;
    import ipf_pkg::*;

    localparam int FRAME_MAX      = 64;   // length bound handed to the block
    localparam int SETTLE_CYCLES  = 8;    // queue + output register, with margin
    localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000; // cycles with no handshake on either side
    localparam int PHASE_BYTES    = 60;   // framed bytes per random phase
    // index beyond the register file; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [7:0] byte_q[$];

    // one frame report, as unpacked from m_tdata
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] command;
        logic [6:0]  length;
        logic [31:0] angle;
    } frame_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAD_BYTE;
    logic [7:0]           cfg_wdata = 8'h00;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    imu_packet_framer_lrc_check_top #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framer predictor: own copy of the registers and the frame state
    // ------------------------------------------------------------------
    logic [7:0]    head_val, end1_val, end2_val;
    logic          collecting;
    int            stored_count;
    logic [15:0]   sum_acc;     // bytes from position 1 that have left the window
    logic [7:0]    window [4];  // newest stored byte at [0]
    logic [15:0]   cmd_acc;
    logic [31:0]   angle_acc;
    frame_report_t reports_due[$];

    // run statistics
    int bytes_sent, bytes_framed, reg_writes, mismatches;
    int seen_by_status [4];

    // stimulus knobs, percent out of a hundred
    int sender_idle_pct, receiver_stall_pct;
    bit hold_req;
    int hold_left;

    function automatic frame_report_t make_report(input logic [1:0] st);
        frame_report_t r;
        r.status  = st;
        r.command = cmd_acc;
        r.length  = stored_count[6:0];
        r.angle   = (stored_count >= 23) ? angle_acc : 32'h0;
        return r;
    endfunction

    task automatic clear_frame_state();
        stored_count = 0;
        sum_acc      = '0;
        window       = '{default: 8'h00};
        cmd_acc      = '0;
        angle_acc    = '0;
    endtask

    // Advance the predictor by one accepted byte; queues a report when one is due.
    task automatic track_rx_byte(input logic [7:0] b);
        int         pos;
        logic [1:0] st;
        if (!collecting) begin
            if (b != head_val) return;
            collecting = 1'b1;
            clear_frame_state();
        end
        bytes_framed++;
        if (stored_count >= FRAME_MAX) begin
            // length bound: byte dropped, back to hunting
            reports_due.push_back(make_report(STAT_OVERFLOW));
            collecting = 1'b0;
            return;
        end
        pos = stored_count;
        if (pos >= 5) sum_acc = sum_acc + window[3];
        window[3] = window[2];
        window[2] = window[1];
        window[1] = window[0];
        window[0] = b;
        if (pos == 3) cmd_acc[7:0] = b;
        if (pos == 4) cmd_acc[15:8] = b;
        if (pos >= 19 && pos <= 22) angle_acc[8*(pos-19) +: 8] = b;
        stored_count = pos + 1;
        if (stored_count >= 2 && window[1] == end1_val && window[0] == end2_val) begin
            st = STAT_MISMATCH;
            if (stored_count >= 5 && {window[2], window[3]} == sum_acc) st = STAT_OK;
            reports_due.push_back(make_report(st));
            collecting = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Request side: one byte per call, random gaps before it
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        track_rx_byte(b);
    endtask

    task automatic send_bytes(input byte_q q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Head, body, little-endian check word, end pair; spoil flips one check bit.
    task automatic send_frame(input byte_q body, input bit spoil);
        logic [15:0] word;
        word = '0;
        foreach (body[i]) word = word + body[i];
        if (spoil) word = word ^ (16'd1 << $urandom_range(15));
        send_byte(head_val);
        send_bytes(body);
        send_byte(word[7:0]);
        send_byte(word[15:8]);
        send_byte(end1_val);
        send_byte(end2_val);
    endtask

    function automatic byte_q random_body();
        byte_q q;
        int    n, r;
        r = $urandom_range(99);
        if (r < 10)      n = $urandom_range(3);
        else if (r < 70) n = $urandom_range(30, 4);
        else if (r < 92) n = $urandom_range(58, 31);
        else             n = $urandom_range(62, 59); // 60 and up overflows
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // Drop tvalid, wait for every report, then let the pipeline drain.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_HEAD_BYTE:  head_val = val;
            CFG_END_FIRST:  end1_val = val;
            CFG_END_SECOND: end2_val = val;
            default: ;      // unused index, no effect
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input logic [7:0] h, input logic [7:0] e1, input logic [7:0] e2);
        write_reg(CFG_HEAD_BYTE, h);
        write_reg(CFG_END_FIRST, e1);
        write_reg(CFG_END_SECOND, e2);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Checker: each accepted report against the oldest expected one
    always @(posedge aclk) begin
        frame_report_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tdata[1:0];
            got.command = m_tdata[17:2];
            got.length  = m_tdata[24:18];
            got.angle   = m_tdata[56:25];
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected report st=%0d cmd=%h len=%0d ang=%h",
                             $realtime, got.status, got.command, got.length, got.angle);
            end else begin
                want = reports_due.pop_front();
                seen_by_status[want.status]++;
                if (got != want || m_tdata[63:57] != '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] report mismatch: exp st=%0d cmd=%h len=%0d ang=%h",
                                  " | got st=%0d cmd=%h len=%0d ang=%h pad=%h"},
                                 $realtime, want.status, want.command, want.length,
                                 want.angle, got.status, got.command, got.length,
                                 got.angle, m_tdata[63:57]);
                end
            end
        end
    end

    // Watchdog: too long without any handshake means a hang
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
                     quiet_cycles, reports_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Well-formed frames at reset settings: minimal, command bytes, angle bytes.
    task automatic test_basic_frames();
        byte_q body;
        send_frame('{}, 1'b0);                                // shortest valid frame
        send_frame('{8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b0);      // command word FFFF
        body = '{};
        for (int i = 0; i < 22; i++) body.push_back(8'(i * 11 + 3));
        send_frame(body, 1'b0);                               // angle from body bytes
        body = '{};
        repeat (18) body.push_back(8'hFF);
        send_frame(body, 1'b0);                               // exactly 23 bytes
    endtask

    // Bad check word, short frames, head inside a frame, noise while hunting.
    task automatic test_frame_faults();
        send_frame('{8'h12, 8'h34, 8'h56}, 1'b1);
        send_bytes('{8'h00, 8'hFF, 8'h55, END_FIRST_RST, END_SECOND_RST}); // ignored
        send_bytes('{HEAD_BYTE_RST, END_FIRST_RST, END_SECOND_RST});       // 3 bytes
        send_bytes('{HEAD_BYTE_RST, 8'h80, END_FIRST_RST, END_SECOND_RST}); // 4 bytes
        send_frame('{HEAD_BYTE_RST, HEAD_BYTE_RST, 8'h01}, 1'b0);
    endtask

    // Length bound: 64 bytes that close, then one that overruns.
    task automatic test_length_bound();
        byte_q body;
        repeat (59) body.push_back(8'($urandom_range(255)));
        send_frame(body, 1'b0);
        body.push_back(8'hA5);
        send_frame(body, 1'b0);
        send_frame('{8'h01, 8'h02}, 1'b0);   // recovers after overflow
    endtask

    // Register extremes, end pair overlapping the head, unused index.
    task automatic test_config_writes();
        write_all(8'h00, 8'hFF, 8'hFF);
        repeat (3) send_frame(random_body(), 1'b0);
        write_all(8'hFF, 8'h00, 8'h00);
        repeat (3) send_frame(random_body(), 1'b0);
        write_all(8'h0D, 8'h0D, 8'h0A);
        send_bytes('{8'h0D, 8'h0A});          // closes at two bytes
        send_frame('{8'h44}, 1'b0);
        write_reg(CFG_UNUSED, 8'h55);         // must leave the registers alone
        send_frame('{8'h55, 8'h0D}, 1'b0);
        write_all(HEAD_BYTE_RST, END_FIRST_RST, END_SECOND_RST);
    endtask

    // Long receiver hold-off with the sender pushing: queue fills, s_tready drops.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req = 1'b1;
        repeat (14) send_frame('{8'($urandom_range(255))}, 1'b0);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input bit new_config);
        int    stop_at, pick;
        byte_q q;
        if (new_config)
            write_all(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = bytes_framed + PHASE_BYTES;
        while (bytes_framed < stop_at) begin
            pick = $urandom_range(99);
            q = '{};
            if (pick < 70) begin
                send_frame(random_body(), $urandom_range(99) < 15);
            end else if (pick < 82) begin
                // line noise while hunting, now and then a stray head
                repeat ($urandom_range(8, 1))
                    q.push_back(($urandom_range(9) == 0) ? head_val : 8'($urandom_range(255)));
                send_bytes(q);
            end else if (pick < 92) begin
                // frame cut off before its end pair
                q.push_back(head_val);
                repeat ($urandom_range(12)) q.push_back(8'($urandom_range(255)));
                send_bytes(q);
            end else begin
                // end pair with a random check word
                q.push_back(head_val);
                repeat ($urandom_range(24)) q.push_back(8'($urandom_range(255)));
                q.push_back(end1_val);
                q.push_back(end2_val);
                send_bytes(q);
            end
        end
        wait_idle();
    endtask

    initial begin
        head_val   = HEAD_BYTE_RST;
        end1_val   = END_FIRST_RST;
        end2_val   = END_SECOND_RST;
        collecting = 1'b0;
        clear_frame_state();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req  = 1'b0;
        hold_left = 0;
        seen_by_status = '{default: 0};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_frames();
        test_frame_faults();
        test_length_bound();
        wait_idle();
        sender_idle_pct    = 38;
        receiver_stall_pct = 38;
        test_config_writes();
        test_backpressure();
        wait_idle();

        run_random_phase(0, 0, 1'b0);
        run_random_phase(64, 0, 1'b1);
        run_random_phase(0, 64, 1'b1);
        run_random_phase(38, 38, 1'b1);
        write_all(HEAD_BYTE_RST, END_FIRST_RST, END_SECOND_RST);
        run_random_phase(0, 0, 1'b0);
        wait_idle();

        $display("Summary: %0d bytes sent (%0d inside frames), %0d register writes",
                 bytes_sent, bytes_framed, reg_writes);
        $display("Reports: %0d check ok, %0d check mismatch, %0d overflow, %0d errors",
                 seen_by_status[STAT_OK], seen_by_status[STAT_MISMATCH],
                 seen_by_status[STAT_OVERFLOW], mismatches);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
